// File: sv/irfl_pkg.sv
// ----------------------------------------------------------------------------
// irfl_pkg
// Types and codes shared by the ID range free list controller and datapath.
// ----------------------------------------------------------------------------
package irfl_pkg;

	localparam int IdW = 32;

	// operation codes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_TEST    = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_FREE  = 2'd3;

	// configuration register indexes
	localparam logic CFG_FIRST_ID = 1'b0;
	localparam logic CFG_LAST_ID  = 1'b1;

	typedef struct packed {
		logic [1:0]     op;
		logic [IdW-1:0] id;
	} in_t;

	typedef struct packed {
		logic [1:0]     status;
		logic [IdW-1:0] given_id;
		logic           is_free;
	} out_t;

	typedef struct packed {
		logic [IdW-1:0] first;
		logic [IdW-1:0] last;
	} ent_t;

	// table write selection
	typedef enum logic [3:0] {
		WR_NONE,
		WR_LOAD,
		WR_ALLOC,
		WR_SHDN,
		WR_SHUP,
		WR_BOTH,
		WR_LOW,
		WR_HIGH,
		WR_NEW
	} wr_sel_t;

	typedef struct packed {
		logic       take;
		logic       idx_inc;
		logic       idx_dec;
		logic       idx_to_count;
		logic       rd_prev;
		wr_sel_t    wr_sel;
		logic       save_prev;
		logic       save_pos;
		logic       set_status;
		logic [1:0] status;
		logic       set_given;
		logic       set_free;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cnt_zero;
		logic       idx_end;
		logic       full;
		logic       in_rng;
		logic       first_gt;
		logic       single;
		logic       jl;
		logic       jh;
		logic       at_pos;
		logic       out_free;
	} sts_t;

	typedef enum logic [8:0] {
		S_LOAD = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_CHK  = 9'b000000100,
		S_EVAL = 9'b000001000,
		S_DCHK = 9'b000010000,
		S_DWR  = 9'b000100000,
		S_UCHK = 9'b001000000,
		S_UWR  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

endpackage

// File: sv/irfl_ctrl.sv
// ----------------------------------------------------------------------------
// irfl_ctrl
// Sequencer: walks the range table, issues writes and shifts, posts results.
// ----------------------------------------------------------------------------
module irfl_ctrl import irfl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.wr_sel = WR_NONE;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				cmd.wr_sel = WR_LOAD;
				state_d    = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				case (sts.op)
					OP_ALLOC: begin
						if (sts.cnt_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
							state_d        = S_DONE;
						end else begin
							state_d = S_EVAL;
						end
					end
					OP_TEST: begin
						state_d = sts.idx_end ? S_DONE : S_EVAL;
					end
					OP_RELEASE: begin
						if (!sts.idx_end) begin
							state_d = S_EVAL;
						end else if (sts.jl) begin
							cmd.wr_sel = WR_LOW;
							state_d    = S_DONE;
						end else if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
							state_d        = S_DONE;
						end else begin
							cmd.save_pos     = 1'b1;
							cmd.idx_to_count = 1'b1;
							state_d          = S_UCHK;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_EVAL: begin
				case (sts.op)
					OP_ALLOC: begin
						cmd.set_given = 1'b1;
						if (sts.single) begin
							cmd.idx_inc = 1'b1;
							state_d     = S_DCHK;
						end else begin
							cmd.wr_sel = WR_ALLOC;
							state_d    = S_DONE;
						end
					end
					OP_TEST: begin
						if (sts.in_rng) begin
							cmd.set_free = 1'b1;
							state_d      = S_DONE;
						end else if (sts.first_gt) begin
							state_d = S_DONE;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_CHK;
						end
					end
					OP_RELEASE: begin
						if (sts.in_rng) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FREE;
							state_d        = S_DONE;
						end else if (sts.first_gt) begin
							if (sts.jl && sts.jh) begin
								// bridge two ranges, then close the gap
								cmd.wr_sel  = WR_BOTH;
								cmd.idx_inc = 1'b1;
								state_d     = S_DCHK;
							end else if (sts.jl) begin
								cmd.wr_sel = WR_LOW;
								state_d    = S_DONE;
							end else if (sts.jh) begin
								cmd.wr_sel = WR_HIGH;
								state_d    = S_DONE;
							end else if (sts.full) begin
								cmd.set_status = 1'b1;
								cmd.status     = ST_FULL;
								state_d        = S_DONE;
							end else begin
								cmd.save_pos     = 1'b1;
								cmd.idx_to_count = 1'b1;
								state_d          = S_UCHK;
							end
						end else begin
							cmd.save_prev = 1'b1;
							cmd.idx_inc   = 1'b1;
							state_d       = S_CHK;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_DCHK: begin
				if (sts.idx_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				cmd.wr_sel  = WR_SHDN;
				cmd.idx_inc = 1'b1;
				state_d     = S_DCHK;
			end
			S_UCHK: begin
				if (sts.at_pos) begin
					cmd.wr_sel  = WR_NEW;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_UWR;
				end
			end
			S_UWR: begin
				cmd.wr_sel  = WR_SHUP;
				cmd.idx_dec = 1'b1;
				state_d     = S_UCHK;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/irfl_dp.sv
// ----------------------------------------------------------------------------
// irfl_dp
// Datapath: range table memory, index and count, item and result registers.
// ----------------------------------------------------------------------------
module irfl_dp import irfl_pkg::*; #(
	parameter int MAX_RANGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  in_t            in_data,
	input  logic           out_stall,
	output logic           out_valid,
	output out_t           out_data,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [IdW-1:0] cfg_wdata,
	input  cmd_t           cmd,
	output sts_t           sts
);

	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);

	ent_t           mem [2**AW];
	ent_t           rd_q;
	ent_t           prev_q;
	logic [CW-1:0]  idx_q, cnt_q, pos_q;
	logic [IdW-1:0] first_q, last_q, id_q;
	logic [1:0]     op_q, status_q;
	logic [IdW-1:0] given_q;
	logic           free_q;
	logic           out_valid_q;
	out_t           out_q;

	logic [CW-1:0]  idx_m1;
	logic [AW-1:0]  raddr, waddr;
	ent_t           wdata;
	logic           we;
	logic [IdW-1:0] nf, nl;

	assign idx_m1 = idx_q - CW'(1);
	assign raddr  = cmd.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

	// config write values
	assign nf = (cfg_idx == CFG_FIRST_ID) ? cfg_wdata : first_q;
	assign nl = (cfg_idx == CFG_LAST_ID)  ? cfg_wdata : last_q;

	always_comb begin
		we    = 1'b1;
		waddr = idx_q[AW-1:0];
		wdata = rd_q;
		if (cfg_we) begin
			waddr = '0;
			wdata = '{first: nf, last: nl};
		end else begin
			case (cmd.wr_sel)
				WR_LOAD: begin
					waddr = '0;
					wdata = '{first: first_q, last: last_q};
				end
				WR_ALLOC: begin
					waddr = '0;
					wdata = '{first: rd_q.first + IdW'(1), last: rd_q.last};
				end
				WR_SHDN: begin
					waddr = idx_m1[AW-1:0];
				end
				WR_SHUP: begin
					waddr = idx_q[AW-1:0];
				end
				WR_BOTH: begin
					waddr = idx_m1[AW-1:0];
					wdata = '{first: prev_q.first, last: rd_q.last};
				end
				WR_LOW: begin
					waddr = idx_m1[AW-1:0];
					wdata = '{first: prev_q.first, last: id_q};
				end
				WR_HIGH: begin
					wdata = '{first: id_q, last: rd_q.last};
				end
				WR_NEW: begin
					wdata = '{first: id_q, last: id_q};
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= IdW'(1);
			last_q      <= '1;
			cnt_q       <= CW'(1);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				first_q <= nf;
				last_q  <= nl;
				cnt_q   <= (nf <= nl) ? CW'(1) : '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.take) begin
				idx_q <= '0;
			end else if (cmd.idx_to_count) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q     <= in_data.op;
			id_q     <= in_data.id;
			status_q <= ST_OK;
			given_q  <= '0;
			free_q   <= 1'b0;
		end else begin
			if (cmd.set_status) status_q <= cmd.status;
			if (cmd.set_given)  given_q  <= rd_q.first;
			if (cmd.set_free)   free_q   <= 1'b1;
		end
		if (cmd.save_prev) prev_q <= rd_q;
		if (cmd.save_pos)  pos_q  <= idx_q;
		if (cmd.load_out) begin
			out_q <= '{status: status_q, given_id: given_q, is_free: free_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.op       = op_q;
		sts.cnt_zero = (cnt_q == '0);
		sts.idx_end  = (idx_q >= cnt_q);
		sts.full     = (cnt_q == CW'(MAX_RANGES));
		sts.in_rng   = (rd_q.first <= id_q) && (id_q <= rd_q.last);
		sts.first_gt = (rd_q.first > id_q);
		sts.single   = (rd_q.first == rd_q.last);
		// range below ends right under id (no wrap at all-ones)
		sts.jl       = (idx_q != '0) && (prev_q.last != '1)
			&& (prev_q.last + IdW'(1) == id_q);
		sts.jh       = (id_q != '1) && (id_q + IdW'(1) == rd_q.first);
		sts.at_pos   = (idx_q == pos_q);
		sts.out_free = !out_valid_q || !out_stall;
	end

endmodule

// File: sv/id_range_free_list.sv
// ----------------------------------------------------------------------------
// id_range_free_list
// Free list of 32-bit IDs held as a sorted table of disjoint free ranges.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | in_t  {op, id}
//  out     | out | out_valid/out_stall| out_t {status, given_id, is_free}
//  cfg     | in  | cfg_we             | cfg_idx, cfg_wdata
//
// One item at a time. An allocate that empties a single-ID range shifts the
// ranges after it down. Test and release scan the table one range at a time;
// a new range or a merge of two shifts the table tail one entry at a time
// through the single table write port. The first state after reset loads entry 0.
// A finished result waits in the output register while the next item enters.
// ----------------------------------------------------------------------------
module id_range_free_list import irfl_pkg::*; #(
	parameter int MAX_RANGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  in_t            in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output out_t           out_data,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [IdW-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	irfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	irfl_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item while busy");

	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full)
		else $error("range insert into full table");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result overwrote pending output");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate, release and test items into the ID range free list and
// checks every result against a range table kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top import irfl_pkg::*; ();

	localparam int NRANGES = 16;
	localparam int CYCLE_LIMIT = 2000000;

	class id_pool_board;
		logic [31:0] lo_id, hi_id;
		logic [31:0] rfirst[NRANGES];
		logic [31:0] rlast[NRANGES];
		int          rcount;
		out_t        pending[$];
		int          errors;
		int          checked;

		function void reload();
			for (int k = 0; k < NRANGES; k++) begin
				rfirst[k] = '0;
				rlast[k] = '0;
			end
			if (lo_id <= hi_id) begin
				rfirst[0] = lo_id;
				rlast[0] = hi_id;
				rcount = 1;
			end else begin
				rcount = 0;
			end
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == CFG_FIRST_ID) lo_id = val;
			else hi_id = val;
			reload();
		endfunction

		function void drop_at(int pos);
			for (int k = pos; k + 1 < rcount; k++) begin
				rfirst[k] = rfirst[k+1];
				rlast[k] = rlast[k+1];
			end
			rcount--;
		endfunction

		function bit holds(logic [31:0] id);
			for (int k = 0; k < rcount; k++) begin
				if (id >= rfirst[k] && id <= rlast[k]) return 1;
				if (rfirst[k] > id) return 0;
			end
			return 0;
		endfunction

		function logic [1:0] give_back(logic [31:0] id);
			int pos;
			bit jl, jh;
			pos = 0;
			if (holds(id)) return ST_FREE;
			while (pos < rcount && rfirst[pos] < id) pos++;
			jl = pos > 0 && ({1'b0, rlast[pos-1]} + 33'd1 == {1'b0, id});
			jh = pos < rcount && ({1'b0, id} + 33'd1 == {1'b0, rfirst[pos]});
			if (jl && jh) begin
				rlast[pos-1] = rlast[pos];
				drop_at(pos);
			end else if (jl) begin
				rlast[pos-1] = id;
			end else if (jh) begin
				rfirst[pos] = id;
			end else begin
				if (rcount >= NRANGES) return ST_FULL;
				for (int k = rcount; k > pos; k--) begin
					rfirst[k] = rfirst[k-1];
					rlast[k] = rlast[k-1];
				end
				rfirst[pos] = id;
				rlast[pos] = id;
				rcount++;
			end
			return ST_OK;
		endfunction

		function void note_item(in_t it);
			out_t r;
			r = '0;
			case (it.op)
				OP_ALLOC: begin
					if (rcount == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.given_id = rfirst[0];
						if (rfirst[0] == rlast[0]) drop_at(0);
						else rfirst[0]++;
					end
				end
				OP_RELEASE: r.status = give_back(it.id);
				OP_TEST: r.is_free = holds(it.id);
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task check_result(out_t got);
			out_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				report_err("result with nothing expected", got, '0);
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) report_err("status", got, exp_r);
			if (got.given_id !== exp_r.given_id) report_err("given_id", got, exp_r);
			if (got.is_free !== exp_r.is_free) report_err("is_free", got, exp_r);
		endtask

		task report_err(string what, out_t got, out_t exp_r);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got %h exp %h at %0t", what, got, exp_r, $realtime);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 0;
	out_t        out_data;
	logic        cfg_we = 0;
	logic        cfg_idx = 0;
	logic [31:0] cfg_wdata = '0;

	id_pool_board board = new();
	int  cycles = 0;
	bit  hold_long = 0;
	bit  rx_quiet = 0;
	int  n_sent = 0;
	int  n_cfg = 0;

	id_range_free_list #(.MAX_RANGES(NRANGES)) dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && out_valid && !out_stall) board.check_result(out_data);

	// receiver stall pattern; long hold-off on request
	initial begin : rx_proc
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				hold_long = 0;
			end else if (rx_quiet) begin
				out_stall <= 0;
			end else begin
				if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [31:0] id);
		in_t it;
		it.op = op;
		it.id = id;
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
		n_sent++;
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		board.set_reg(idx, val);
		n_cfg++;
		@(posedge clk);
	endtask

	// ids mostly near the low end of the pool, some near the high end or random, so that releases hit real gaps
	function automatic logic [31:0] pick_id();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return board.hi_id - $urandom_range(0, 3);
			2: return board.lo_id - $urandom_range(0, 2);
			default: return board.lo_id + $urandom_range(0, 40);
		endcase
	endfunction

	task automatic random_phase(int n);
		int burst;
		int r;
		logic [1:0] op;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
				burst = $urandom_range(1, 20);
			end
			burst--;
			r = $urandom_range(0, 99);
			op = r < 40 ? OP_ALLOC : r < 75 ? OP_RELEASE : r < 97 ? OP_TEST : OP_NOP;
			send_item(op, pick_id());
		end
		drain();
	endtask

	initial begin
		board.lo_id = 32'd1;
		board.hi_id = 32'hFFFF_FFFF;
		board.reload();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// directed: reset pool edges
		send_item(OP_TEST, 32'd0);
		send_item(OP_TEST, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, '0);
		send_item(OP_RELEASE, 32'd1);
		send_item(OP_RELEASE, 32'd1);
		send_item(OP_RELEASE, 32'd0);
		send_item(OP_NOP, 32'h5A5A_A5A5);
		drain();
		// two-id pool: empty alloc, merges on both sides, full table
		write_reg(CFG_LAST_ID, 32'd1);
		write_reg(CFG_FIRST_ID, 32'd0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_RELEASE, 32'd0);
		send_item(OP_RELEASE, 32'd1);
		send_item(OP_TEST, 32'd1);
		for (int k = 0; k < 17; k++) send_item(OP_RELEASE, 32'd10 + 2 * k);
		send_item(OP_RELEASE, 32'd11);
		drain();
		// empty table after reversed bounds
		write_reg(CFG_FIRST_ID, 32'hFFFF_FFFF);
		write_reg(CFG_LAST_ID, 32'hFFFF_FFF0);
		send_item(OP_ALLOC, '0);
		send_item(OP_RELEASE, 32'hFFFF_FFFF);
		send_item(OP_RELEASE, 32'hFFFF_FFFE);
		drain();

		// random phases over several pool settings
		write_reg(CFG_FIRST_ID, 32'd0);
		write_reg(CFG_LAST_ID, 32'hFFFF_FFFF);
		random_phase(150);
		write_reg(CFG_FIRST_ID, 32'd100);
		write_reg(CFG_LAST_ID, 32'd130);
		random_phase(150);

		// long output hold-off while items keep coming
		fork
			hold_long = 1;
			random_phase(60);
		join
		write_reg(CFG_FIRST_ID, 32'hFFFF_FFE0);
		write_reg(CFG_LAST_ID, 32'hFFFF_FFFF);
		random_phase(150);
		write_reg(CFG_FIRST_ID, $urandom());
		write_reg(CFG_LAST_ID, board.lo_id + $urandom_range(0, 20));
		rx_quiet = 1;
		random_phase(60);
		rx_quiet = 0;
		random_phase(130);

		$display("covered %0d items, %0d register writes, %0d results checked",
			n_sent, n_cfg, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", board.errors,
				board.pending.size());
			$display("status: fail");
		end
		$finish;
	end
endmodule

// File: files.f
sv/irfl_pkg.sv
sv/irfl_ctrl.sv
sv/irfl_dp.sv
sv/id_range_free_list.sv
sim/tb_top.sv
